// ===== rtl/bthg_pkg.sv =====
// ----------------------------------------------------------------------------
// bthg_pkg
// types and constants shared by the tap and hold gesture decoder
// ----------------------------------------------------------------------------
`default_nettype none

package bthg_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned ACT_W   = 3;

    localparam logic [ACT_W-1:0]   ACT_NONE  = 3'd0;
    localparam logic [ACT_W-1:0]   ACT_ERROR = 3'd4;
    localparam logic [COUNT_W-1:0] MAX_TAPS  = 3'd3;

    localparam logic [1:0] CFG_DEBOUNCE_TIME   = 2'd0;
    localparam logic [1:0] CFG_SHORT_PRESS_MAX = 2'd1;
    localparam logic [1:0] CFG_HOLD_PRESS_MIN  = 2'd2;
    localparam logic [1:0] CFG_TAP_GAP_MAX     = 2'd3;

    localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;
    localparam logic [CFG_W-1:0] SHORT_PRESS_MAX_RST = 16'd300;
    localparam logic [CFG_W-1:0] HOLD_PRESS_MIN_RST  = 16'd800;
    localparam logic [CFG_W-1:0] TAP_GAP_MAX_RST     = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] short_press_max;
        logic [CFG_W-1:0] hold_press_min;
        logic [CFG_W-1:0] tap_gap_max;
    } cfg_t;

    typedef struct packed {
        logic               previous_raw;
        logic               stable_pressed;
        logic [TIME_W-1:0]  raw_change_time;
        logic [TIME_W-1:0]  press_begin_time;
        logic [TIME_W-1:0]  release_time;
        logic [COUNT_W-1:0] tap_count;
        logic               hold_done;
        logic               awaiting_hold;
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/bthg_step.sv =====
// ----------------------------------------------------------------------------
// bthg_step
// next state and action for one sample: debounce, tap count, hold, errors
// ----------------------------------------------------------------------------
`default_nettype none

module bthg_step
    import bthg_pkg::*;
(
    input  wire state_t             cur,
    input  wire cfg_t               cfg,
    input  wire logic               raw,
    input  wire logic [TIME_W-1:0]  now,
    output state_t                  nxt,
    output logic [ACT_W-1:0]        action
);

    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_release;
    logic              settled;
    logic              hold_reached;
    logic              gap_expired;
    logic              is_short;
    logic              is_medium;
    logic [COUNT_W-1:0] taps_inc;

    assign change_time   = (raw != cur.previous_raw) ? now : cur.raw_change_time;
    assign since_change  = now - change_time;
    assign since_press   = now - cur.press_begin_time;
    assign since_release = now - cur.release_time;
    assign settled       = since_change >= {16'd0, cfg.debounce_time};
    assign hold_reached  = since_press >= {16'd0, cfg.hold_press_min};
    assign gap_expired   = since_release > {16'd0, cfg.tap_gap_max};
    assign is_short      = since_press < {16'd0, cfg.short_press_max};
    assign is_medium     = since_press < {16'd0, cfg.hold_press_min};
    assign taps_inc      = cur.tap_count + 3'd1;

    always_comb
    begin
        nxt                 = cur;
        action              = ACT_NONE;
        nxt.raw_change_time = change_time;
        nxt.previous_raw    = raw;
        if (settled)
        begin
            if (raw == cur.stable_pressed)
            begin
                if (cur.stable_pressed && cur.awaiting_hold && !cur.hold_done && hold_reached)
                begin
                    nxt.hold_done     = 1'b1;
                    action            = (cur.tap_count >= 3'd1 && cur.tap_count <= MAX_TAPS)
                                        ? cur.tap_count : ACT_ERROR;
                    nxt.tap_count     = '0;
                    nxt.awaiting_hold = 1'b0;
                end
                if (!cur.stable_pressed && cur.tap_count != '0 && !cur.awaiting_hold
                    && gap_expired)
                begin
                    action            = ACT_ERROR;
                    nxt.tap_count     = '0;
                    nxt.awaiting_hold = 1'b0;
                    nxt.hold_done     = 1'b0;
                end
            end
            else
            begin
                nxt.stable_pressed = raw;
                if (raw)
                begin
                    nxt.press_begin_time = now;
                    nxt.hold_done        = 1'b0;
                    if (cur.tap_count != '0 && gap_expired)
                    begin
                        action        = ACT_ERROR;
                        nxt.tap_count = '0;
                    end
                    nxt.awaiting_hold = 1'b1;
                end
                else
                begin
                    nxt.release_time = now;
                    if (cur.hold_done)
                    begin
                        nxt.hold_done     = 1'b0;
                        nxt.awaiting_hold = 1'b0;
                    end
                    else if (is_short)
                    begin
                        nxt.awaiting_hold = 1'b0;
                        if (taps_inc > MAX_TAPS)
                        begin
                            action        = ACT_ERROR;
                            nxt.tap_count = '0;
                        end
                        else
                        begin
                            nxt.tap_count = taps_inc;
                        end
                    end
                    else if (is_medium)
                    begin
                        action            = ACT_ERROR;
                        nxt.tap_count     = '0;
                        nxt.awaiting_hold = 1'b0;
                    end
                    else
                    begin
                        nxt.tap_count     = '0;
                        nxt.awaiting_hold = 1'b0;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/button_tap_hold_gesture_decoder_core.sv =====
// ----------------------------------------------------------------------------
// button_tap_hold_gesture_decoder_core
// debounces a sampled button level and decodes tap-tap-hold gestures
//
//   channel   direction  tdata bits (lowest first)
//   s_axis    in         [0] raw_pressed, [32:1] now_ms, [39:33] zero
//   m_axis    out        [2:0] action, [7:3] zero
//   cfg       in         cfg_we, cfg_index, cfg_data[15:0]
//
// one transfer in per cycle while the output is not stalled, each giving exactly one action transfer out
// the next cycle; the decode is combinational compares on the state
// registers. reset loads the default thresholds and clears the gesture state and output valid, not the action register.
// a stalled output holds its action and input is still taken whenever the
// output register is empty or is being drained in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module button_tap_hold_gesture_decoder_core
    import bthg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // raw_pressed, now_ms
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // action
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t             cfg_reg;
    state_t           state_reg;
    state_t           state_next;
    logic [ACT_W-1:0] act_reg;
    logic [ACT_W-1:0] act_next;
    logic             out_valid_reg;
    logic             in_xfer;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, act_reg};

    bthg_step u_step (
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .raw    (s_axis_tdata[0]),
        .now    (s_axis_tdata[32:1]),
        .nxt    (state_next),
        .action (act_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time   <= DEBOUNCE_TIME_RST;
            cfg_reg.short_press_max <= SHORT_PRESS_MAX_RST;
            cfg_reg.hold_press_min  <= HOLD_PRESS_MIN_RST;
            cfg_reg.tap_gap_max     <= TAP_GAP_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_TIME:   cfg_reg.debounce_time   <= cfg_data;
                CFG_SHORT_PRESS_MAX: cfg_reg.short_press_max <= cfg_data;
                CFG_HOLD_PRESS_MIN:  cfg_reg.hold_press_min  <= cfg_data;
                CFG_TAP_GAP_MAX:     cfg_reg.tap_gap_max     <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg <= act_next;
        end
    end

    a_tap_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.tap_count <= MAX_TAPS)
        else $error("tap count beyond limit");

    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= ACT_ERROR))
        else $error("action code out of range");

    a_hold_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.hold_done && state_reg.awaiting_hold))
        else $error("hold detected while still awaiting hold");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted transfer gave no result");

endmodule

`default_nettype wire

// ===== sim/button_tap_hold_gesture_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_tap_hold_gesture_decoder_core_tb
// self-checking bench for the tap and hold gesture decoder. a queue of raw
// button samples, built from tap, gap and hold sequences plus bounce and
// random noise, is streamed in under several threshold settings and
// handshake pacings. every input transfer is decoded by an in-bench model and
// each action transfer out is compared in order against its prediction
// ----------------------------------------------------------------------------
module button_tap_hold_gesture_decoder_core_tb;
    import bthg_pkg::*;

    localparam int unsigned SEG_ITEMS   = 325;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              raw_pressed;
    } sample_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;     // raw_pressed, now_ms
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // action
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = CFG_DEBOUNCE_TIME;
    logic [15:0] cfg_data      = '0;

    sample_t          sample_q[$];
    logic [ACT_W-1:0] action_q[$];
    cfg_t             thr;
    state_t           gs;
    logic [TIME_W-1:0] tick_ms;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned fail_count    = 0;
    int unsigned queued_count  = 0;
    int unsigned cycle_count   = 0;
    int unsigned cfg_settings  = 0;
    int unsigned act_seen [0:4] = '{default: 0};

    button_tap_hold_gesture_decoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void clear_taps();
        gs.tap_count     = '0;
        gs.awaiting_hold = 1'b0;
    endfunction

    function automatic logic [ACT_W-1:0] decode_sample(input logic raw,
                                                       input logic [TIME_W-1:0] now);
        logic [ACT_W-1:0]  act;
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] since_press;
        logic [TIME_W-1:0] since_release;
        act = ACT_NONE;
        if (raw != gs.previous_raw)
            gs.raw_change_time = now;
        gs.previous_raw = raw;
        since_change  = now - gs.raw_change_time;
        since_press   = now - gs.press_begin_time;
        since_release = now - gs.release_time;
        if (since_change < TIME_W'(thr.debounce_time))
            return act;
        if (raw == gs.stable_pressed)
        begin
            if (gs.stable_pressed && gs.awaiting_hold && !gs.hold_done &&
                since_press >= TIME_W'(thr.hold_press_min))
            begin
                gs.hold_done = 1'b1;
                act = (gs.tap_count >= 1 && gs.tap_count <= MAX_TAPS) ? gs.tap_count
                                                                       : ACT_ERROR;
                clear_taps();
            end
            if (!gs.stable_pressed && gs.tap_count != 0 && !gs.awaiting_hold &&
                since_release > TIME_W'(thr.tap_gap_max))
            begin
                act = ACT_ERROR;
                clear_taps();
                gs.hold_done = 1'b0;
            end
        end
        else
        begin
            gs.stable_pressed = raw;
            if (raw)
            begin
                gs.press_begin_time = now;
                gs.hold_done        = 1'b0;
                if (gs.tap_count != 0 && since_release > TIME_W'(thr.tap_gap_max))
                begin
                    act = ACT_ERROR;
                    clear_taps();
                end
                gs.awaiting_hold = 1'b1;
            end
            else
            begin
                gs.release_time = now;
                if (gs.hold_done)
                begin
                    gs.hold_done     = 1'b0;
                    gs.awaiting_hold = 1'b0;
                end
                else if (since_press < TIME_W'(thr.short_press_max))
                begin
                    gs.tap_count     = gs.tap_count + 1'b1;
                    gs.awaiting_hold = 1'b0;
                    if (gs.tap_count > MAX_TAPS)
                    begin
                        act = ACT_ERROR;
                        clear_taps();
                    end
                end
                else if (since_press < TIME_W'(thr.hold_press_min))
                begin
                    act = ACT_ERROR;
                    clear_taps();
                end
                else
                    clear_taps();
            end
        end
        return act;
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'b0, sample_q.pop_front()};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // action monitor: check outgoing transfer, then predict the incoming one
    always @(posedge clk or negedge rst_n)
    begin
        logic [ACT_W-1:0] want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (action_q.size() == 0)
                begin
                    $error("action: expected nothing, got %0d", m_axis_tdata[ACT_W-1:0]);
                    fail_count++;
                end
                else
                begin
                    want = action_q.pop_front();
                    if (m_axis_tdata[ACT_W-1:0] !== want)
                    begin
                        $error("action: expected %0d, got %0d", want,
                               m_axis_tdata[ACT_W-1:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[7:ACT_W] !== '0)
                    begin
                        $error("tdata padding: expected 0, got %0h", m_axis_tdata[7:ACT_W]);
                        fail_count++;
                    end
                    act_seen[want]++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                action_q.push_back(decode_sample(s_axis_tdata[0], s_axis_tdata[32:1]));
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("button_tap_hold_gesture_decoder_core regression: fail");
            $finish;
        end
    end

    task automatic push_sample(input logic raw, input logic [TIME_W-1:0] t);
        sample_t item;
        item.now_ms      = t;
        item.raw_pressed = raw;
        sample_q.push_back(item);
        queued_count++;
    endtask

    task automatic step_sample(input logic raw, input int unsigned dt);
        tick_ms = tick_ms + dt;
        push_sample(raw, tick_ms);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_TIME:   thr.debounce_time   = val;
            CFG_SHORT_PRESS_MAX: thr.short_press_max = val;
            CFG_HOLD_PRESS_MIN:  thr.hold_press_min  = val;
            CFG_TAP_GAP_MAX:     thr.tap_gap_max     = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] short_max,
                                  input logic [CFG_W-1:0] hold_min, input logic [CFG_W-1:0] gap_max);
        write_reg(CFG_DEBOUNCE_TIME, deb);
        write_reg(CFG_SHORT_PRESS_MAX, short_max);
        write_reg(CFG_HOLD_PRESS_MIN, hold_min);
        write_reg(CFG_TAP_GAP_MAX, gap_max);
        cfg_settings++;
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || s_axis_tvalid || action_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int unsigned near_limit(input int unsigned lim);
        case ($urandom_range(0, 5))
            0: return lim;
            1: return (lim == 0) ? 0 : lim - 1;
            2: return lim + 1;
            3: return lim + $urandom_range(0, lim + 10);
            default: return $urandom_range(0, lim);
        endcase
    endfunction

    function automatic int unsigned below_or_near(input int unsigned lim);
        if ($urandom_range(0, 2) != 0)
            return (lim == 0) ? 0 : $urandom_range(0, lim - 1);
        return near_limit(lim);
    endfunction

    // one settled level of the button, lasting span ms from its first sample after any contact bounce
    task automatic add_level(input logic lvl, input int unsigned span_req, input bit want_hold);
        logic [TIME_W-1:0] ts;
        int unsigned       acted;
        int unsigned       last;
        int unsigned       span;
        ts   = tick_ms;
        span = span_req;
        if ($urandom_range(0, 7) == 0)
        begin
            // contact bounce
            push_sample(lvl, ts);
            push_sample(~lvl, ts + 1);
            ts = ts + 2;
        end
        acted = thr.debounce_time + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        if (want_hold && span <= acted + thr.hold_press_min)
            span = acted + thr.hold_press_min + $urandom_range(1, 300);
        if (span <= acted)
            span = acted + $urandom_range(1, 20);
        push_sample(lvl, ts);
        push_sample(lvl, ts + acted);
        last = acted;
        if (want_hold)
        begin
            if (thr.hold_press_min > 1)
                push_sample(lvl, ts + acted + thr.hold_press_min - 1);
            push_sample(lvl, ts + acted + thr.hold_press_min);
            last = acted + thr.hold_press_min;
        end
        repeat ($urandom_range(0, 2))
        begin
            if (last + 1 < span)
            begin
                last = $urandom_range(last + 1, span - 1);
                push_sample(lvl, ts + last);
            end
        end
        tick_ms = ts + span;
    endtask

    task automatic add_gesture();
        repeat ($urandom_range(0, 4))
        begin
            add_level(1'b1, below_or_near(thr.short_press_max), 1'b0);
            add_level(1'b0, below_or_near(thr.tap_gap_max), 1'b0);
        end
        case ($urandom_range(0, 9))
            0: add_level(1'b1, $urandom_range(thr.short_press_max, thr.hold_press_min), 1'b0);
            1: add_level(1'b1, near_limit(thr.hold_press_min), 1'b0);
            2: ;
            default: add_level(1'b1, 0, 1'b1);
        endcase
        add_level(1'b0, near_limit(thr.tap_gap_max), 1'b0);
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 4))
            push_sample(1'($urandom_range(0, 1)), $urandom());
        if ($urandom_range(0, 1) == 0)
            tick_ms = $urandom();
    endtask

    task automatic fill_random(input int unsigned target);
        while (queued_count < target)
        begin
            if ($urandom_range(0, 11) == 0)
                add_noise();
            else
                add_gesture();
        end
    endtask

    initial
    begin
        int unsigned s_lo;
        gs      = '0;
        thr     = {DEBOUNCE_TIME_RST, SHORT_PRESS_MAX_RST, HOLD_PRESS_MIN_RST, TAP_GAP_MAX_RST};
        tick_ms = 32'hFFFF_FE00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed run at reset thresholds, crossing the timestamp wrap
        step_sample(1'b1, 0);
        step_sample(1'b0, 10);     // bounce, never settles
        step_sample(1'b1, 10);
        step_sample(1'b1, 50);
        step_sample(1'b1, 800);    // hold without taps
        step_sample(1'b0, 20);
        step_sample(1'b0, 50);     // release after hold
        step_sample(1'b1, 100);
        step_sample(1'b1, 50);
        step_sample(1'b0, 400);
        step_sample(1'b0, 50);     // medium press
        step_sample(1'b1, 100);
        step_sample(1'b1, 50);
        step_sample(1'b0, 100);
        step_sample(1'b0, 50);     // one tap
        step_sample(1'b1, 100);
        step_sample(1'b1, 50);
        step_sample(1'b1, 800);    // one tap then hold: action one
        step_sample(1'b0, 10);
        step_sample(1'b0, 50);
        step_sample(1'b1, 100);
        step_sample(1'b1, 50);
        step_sample(1'b0, 900);
        step_sample(1'b0, 50);     // long press released before hold seen
        step_sample(1'b1, 100);
        step_sample(1'b1, 50);
        step_sample(1'b0, 100);
        step_sample(1'b0, 50);
        step_sample(1'b0, 1500);   // gap timeout while released
        push_sample(1'b0, 32'hFFFF_FFFF);
        push_sample(1'b1, 32'h0000_0000);
        step_sample(1'b1, 7);      // out of order timestamp
        tick_ms = 32'h0000_0000;
        fill_random(SEG_ITEMS);
        wait_drained();

        for (int seg = 1; seg < 6; seg++)
        begin
            case (seg)
                1:
                begin
                    send_idle_pct = 83;
                    stall_pct     = 0;
                    apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 83;
                    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                end
                3, 4:
                begin
                    send_idle_pct = (seg == 3) ? 10 : 83;
                    stall_pct     = (seg == 3) ? 10 : 0;
                    s_lo = $urandom_range(50, 500);
                    apply_settings(CFG_W'($urandom_range(0, 100)), CFG_W'(s_lo),
                                   CFG_W'(s_lo + $urandom_range(0, 1000)),
                                   CFG_W'($urandom_range(50, 1500)));
                end
                default:
                begin
                    // short limit drawn from 300 to 900, hold limit from 0 to 400, so short may lie above hold
                    send_idle_pct = 0;
                    stall_pct     = 83;
                    apply_settings(CFG_W'($urandom_range(1, 30)), CFG_W'($urandom_range(300, 900)),
                                   CFG_W'($urandom_range(0, 400)),
                                   CFG_W'($urandom_range(0, 65535)));
                end
            endcase
            tick_ms = $urandom();
            fill_random(SEG_ITEMS * (seg + 1));
            wait_drained();
        end
        repeat (8) @(posedge clk);

        $display("checked %0d button samples over %0d threshold settings and four pacings",
                 queued_count, cfg_settings + 1);
        $display("actions: none %0d, one %0d, two %0d, three %0d, error %0d",
                 act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4]);
        if (fail_count == 0)
            $display("button_tap_hold_gesture_decoder_core regression: pass");
        else
            $display("button_tap_hold_gesture_decoder_core regression: fail");
        $finish;
    end

endmodule
